>>> rtl/core/kmascii_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmascii_pkg
// Shared types, constants and key translation tables for the matrix scanner.
// ----------------------------------------------------------------------------
package kmascii_pkg;

  localparam int NUM_ROWS    = 10;
  localparam int ROW_W       = 8;
  localparam int CHAR_W      = 8;
  localparam int KEY_IDX_W   = 7;
  localparam int QUEUE_DEPTH = 8;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int TABLE_LEN   = NUM_ROWS * ROW_W;

  localparam int SHIFT_ROW = 8;
  localparam int CTRL_ROW  = 9;
  localparam int CAPS_ROW  = 6;
  localparam int CTRL_BIT  = 7;
  localparam int CAPS_BIT  = 5;

  localparam logic [ROW_W-1:0]  SHIFT_MASK    = 8'h21;
  localparam logic [ROW_W-1:0]  SHIFT_ROW_SRCH = 8'hde;
  localparam logic [CHAR_W-1:0] CTRL_KEEP     = 8'h1f;

  typedef enum logic {
    CMD_SCAN = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    TBL_SEL_NORMAL = 2'd0,
    TBL_SEL_SHIFT  = 2'd1,
    TBL_SEL_CAPS   = 2'd2
  } tbl_sel_e;

  typedef logic [NUM_ROWS-1:0][ROW_W-1:0] rows_t;

  // Decoder result for one scan.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              caps_key;
  } scan_res_t;

  localparam logic [CHAR_W-1:0] TBL_NORMAL [TABLE_LEN] = '{
    8'h31, 8'h33, 8'h35, 8'h37, 8'h39, 8'h2d, 8'h00, 8'h00,
    8'h32, 8'h34, 8'h36, 8'h38, 8'h30, 8'h00, 8'h00, 8'h00,
    8'h71, 8'h65, 8'h74, 8'h75, 8'h6f, 8'h3d, 8'h00, 8'h00,
    8'h77, 8'h72, 8'h79, 8'h69, 8'h70, 8'h00, 8'h00, 8'h00,
    8'h61, 8'h64, 8'h67, 8'h6a, 8'h6c, 8'h00, 8'h00, 8'h00,
    8'h73, 8'h66, 8'h68, 8'h6b, 8'h3b, 8'h00, 8'h00, 8'h00,
    8'h7a, 8'h63, 8'h62, 8'h6d, 8'h2e, 8'h00, 8'h00, 8'h00,
    8'h78, 8'h76, 8'h6e, 8'h2c, 8'h2f, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h08, 8'h00, 8'h0c, 8'h0d, 8'h00, 8'h00, 8'h00,
    8'h1e, 8'h20, 8'h0a, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam logic [CHAR_W-1:0] TBL_CAPS [TABLE_LEN] = '{
    8'h31, 8'h33, 8'h35, 8'h37, 8'h39, 8'h2d, 8'h00, 8'h00,
    8'h32, 8'h34, 8'h36, 8'h38, 8'h30, 8'h00, 8'h00, 8'h00,
    8'h51, 8'h45, 8'h54, 8'h55, 8'h4f, 8'h3d, 8'h00, 8'h00,
    8'h57, 8'h52, 8'h59, 8'h49, 8'h50, 8'h00, 8'h00, 8'h00,
    8'h41, 8'h44, 8'h47, 8'h4a, 8'h4c, 8'h00, 8'h00, 8'h00,
    8'h53, 8'h46, 8'h48, 8'h4b, 8'h3b, 8'h00, 8'h00, 8'h00,
    8'h5a, 8'h43, 8'h42, 8'h4d, 8'h2e, 8'h00, 8'h00, 8'h00,
    8'h58, 8'h56, 8'h4e, 8'h2c, 8'h2f, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h08, 8'h00, 8'h0c, 8'h0d, 8'h00, 8'h00, 8'h00,
    8'h1e, 8'h20, 8'h0a, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam logic [CHAR_W-1:0] TBL_SHIFT [TABLE_LEN] = '{
    8'h21, 8'h23, 8'h25, 8'h27, 8'h29, 8'h2b, 8'h00, 8'h00,
    8'h22, 8'h24, 8'h26, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h3c, 8'h00, 8'h5d, 8'h40, 8'h3a, 8'h2a, 8'h00, 8'h00,
    8'h3e, 8'h5b, 8'h5c, 8'h3f, 8'h5e, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h60, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h01, 8'h0a, 8'h00, 8'h00, 8'h00,
    8'h1a, 8'h20, 8'h0b, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  function automatic logic [CHAR_W-1:0] key_lookup(tbl_sel_e sel, logic [KEY_IDX_W-1:0] idx);
    logic [CHAR_W-1:0] ch;
    ch = '0;
    if (idx < KEY_IDX_W'(TABLE_LEN)) begin
      case (sel)
        TBL_SEL_SHIFT: ch = TBL_SHIFT[idx];
        TBL_SEL_CAPS:  ch = TBL_CAPS[idx];
        default:       ch = TBL_NORMAL[idx];
      endcase
    end
    return ch;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_next(logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

>>> rtl/core/keyboard_matrix_to_ascii_fifo_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_matrix_to_ascii_fifo_unit
// Key matrix scanner with an 8-entry character ring and caps lock.
// ----------------------------------------------------------------------------
// Each input transaction is either a scan tick (tuser = 0) carrying ten
// 8-bit matrix rows in tdata, or a pop (tuser = 1) whose tdata is ignored.
// A scan picks the first pressed key (row 0 first, lowest bit first; row 8
// shift bits are never picked), translates it with the shift, caps or
// normal table, folds it to a control code while ctrl is held, and pushes
// it into the ring when it is non-zero and differs from the last scan's
// character. A rising edge on the caps key toggles caps lock; the table
// choice uses caps lock from before that toggle. Every transaction yields
// exactly one output transaction: the popped byte (zero on a scan), a
// key-ready flag (ring pointers differ) and the caps lock lamp state.
// The ring never refuses a push and a pop on an empty ring still advances,
// so keep the consumer polling key_ready. Throughput is one transaction
// per clock while the output is not back-pressured. An item passes the
// input register and then the result register, with the ring and scan
// state updated as it moves from the first into the second. Back-pressure
// on the output holds both stages; an empty input register still accepts.
// ----------------------------------------------------------------------------
module keyboard_matrix_to_ascii_fifo_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // row_0 [7:0], row_1 [15:8], ... row_9 [79:72]
  input  logic        s_axis_tuser,   // cmd [0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // key_byte [7:0], key_ready [8], caps_on [9], zero [15:10]
);

  localparam int OUT_W = kmascii_pkg::CHAR_W + 2;

  // Input stage
  logic                  in_valid_d, in_valid_q;
  kmascii_pkg::cmd_e     in_cmd_q;
  kmascii_pkg::rows_t    in_rows_q;

  // Scan / ring state
  logic [kmascii_pkg::CHAR_W-1:0] queue_q [kmascii_pkg::QUEUE_DEPTH];
  logic [kmascii_pkg::PTR_W-1:0]  wr_ptr_d, wr_ptr_q;
  logic [kmascii_pkg::PTR_W-1:0]  rd_ptr_d, rd_ptr_q;
  logic [kmascii_pkg::CHAR_W-1:0] last_char_d, last_char_q;
  logic                           last_caps_d, last_caps_q;
  logic                           caps_lock_d, caps_lock_q;

  // Result stage
  logic                  out_valid_d, out_valid_q;
  logic [OUT_W-1:0]      out_data_d, out_data_q;

  logic                     s_fire, m_fire, step_adv, step_fire;
  logic                     push;
  logic [kmascii_pkg::CHAR_W-1:0] pop_byte;
  kmascii_pkg::scan_res_t   scan;

  assign s_fire    = s_axis_tvalid && s_axis_tready;
  assign m_fire    = m_axis_tvalid && m_axis_tready;
  assign step_adv  = !out_valid_q || m_axis_tready;
  assign step_fire = in_valid_q && step_adv;

  // Take a new item whenever the input register is empty or moves on.
  assign s_axis_tready = !in_valid_q || step_adv;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_fire) begin
      in_valid_d = 1'b1;
    end else if (step_fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_cmd_q  <= kmascii_pkg::cmd_e'(s_axis_tuser);
      in_rows_q <= s_axis_tdata;
    end
  end

  kmascii_decode u_decode (
    .rows_i      (in_rows_q),
    .caps_lock_i (caps_lock_q),
    .res_o       (scan)
  );

  assign pop_byte = queue_q[rd_ptr_q];

  // State update for the item leaving the input register.
  always_comb begin
    wr_ptr_d    = wr_ptr_q;
    rd_ptr_d    = rd_ptr_q;
    last_char_d = last_char_q;
    last_caps_d = last_caps_q;
    caps_lock_d = caps_lock_q;
    push        = 1'b0;
    if (step_fire) begin
      if (in_cmd_q == kmascii_pkg::CMD_POP) begin
        rd_ptr_d = kmascii_pkg::ptr_next(rd_ptr_q);
      end else begin
        push        = (scan.ch != '0) && (scan.ch != last_char_q);
        if (push) begin
          wr_ptr_d = kmascii_pkg::ptr_next(wr_ptr_q);
        end
        last_char_d = scan.ch;
        last_caps_d = scan.caps_key;
        if (scan.caps_key && !last_caps_q) begin
          caps_lock_d = !caps_lock_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      last_char_q <= '0;
      last_caps_q <= 1'b0;
      caps_lock_q <= 1'b0;
    end else begin
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      last_char_q <= last_char_d;
      last_caps_q <= last_caps_d;
      caps_lock_q <= caps_lock_d;
    end
  end

  // Ring storage, no reset: unwritten entries are never meant to be read.
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= scan.ch;
    end
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (step_fire) begin
      out_valid_d = 1'b1;
    end else if (m_fire) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_data_d = {caps_lock_d,
                       (rd_ptr_d != wr_ptr_d),
                       (in_cmd_q == kmascii_pkg::CMD_POP) ? pop_byte : '0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(16 - OUT_W)'(0), out_data_q};

`ifndef SYNTH
  // Caps lock only flips on a completed scan.
  a_caps_only_on_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (caps_lock_q != $past(caps_lock_q))
      |-> $past(step_fire && (in_cmd_q == kmascii_pkg::CMD_SCAN)))
    else $error("caps lock changed without a scan");

  // Read pointer only moves on a completed pop.
  a_rd_only_on_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_ptr_q != $past(rd_ptr_q))
      |-> $past(step_fire && (in_cmd_q == kmascii_pkg::CMD_POP)))
    else $error("read pointer moved without a pop");

  // A freshly loaded result reflects the updated caps lock state.
  a_result_caps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(step_fire) |-> (m_axis_tvalid && (m_axis_tdata[9] == caps_lock_q)))
    else $error("result caps bit disagrees with caps lock");
`endif

endmodule

>>> rtl/core/kmascii_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmascii_decode
// Combinational scan decode: key pick, table translate, ctrl fold.
// ----------------------------------------------------------------------------
module kmascii_decode (
  input  kmascii_pkg::rows_t      rows_i,
  input  logic                    caps_lock_i,
  output kmascii_pkg::scan_res_t  res_o
);

  kmascii_pkg::tbl_sel_e                 tbl_sel;
  logic [kmascii_pkg::KEY_IDX_W-1:0]     key_idx;
  logic                                  key_hit;
  logic [kmascii_pkg::CHAR_W-1:0]        raw_ch;
  logic [kmascii_pkg::CHAR_W-1:0]        ch;

  always_comb begin
    if ((rows_i[kmascii_pkg::SHIFT_ROW] & kmascii_pkg::SHIFT_MASK) != '0) begin
      tbl_sel = kmascii_pkg::TBL_SEL_SHIFT;
    end else if (caps_lock_i) begin
      tbl_sel = kmascii_pkg::TBL_SEL_CAPS;
    end else begin
      tbl_sel = kmascii_pkg::TBL_SEL_NORMAL;
    end
  end

  // Priority pick: lowest row first, lowest bit within row. Rows scanned
  // high to low so the lowest hit overwrites.
  always_comb begin
    logic [kmascii_pkg::ROW_W-1:0] v;
    key_idx = '0;
    key_hit = 1'b0;
    for (int r = kmascii_pkg::NUM_ROWS - 1; r >= 0; r--) begin
      v = rows_i[r];
      if (r == kmascii_pkg::SHIFT_ROW) begin
        v = v & kmascii_pkg::SHIFT_ROW_SRCH;
      end
      if (v != '0) begin
        key_hit = 1'b1;
        for (int b = kmascii_pkg::ROW_W - 1; b >= 0; b--) begin
          if (v[b]) begin
            key_idx = kmascii_pkg::KEY_IDX_W'(r * kmascii_pkg::ROW_W + b);
          end
        end
      end
    end
  end

  assign raw_ch = key_hit ? kmascii_pkg::key_lookup(tbl_sel, key_idx) : '0;

  // Ctrl folds A.._ and a..z to control codes; '@' is left alone.
  always_comb begin
    ch = raw_ch;
    if (rows_i[kmascii_pkg::CTRL_ROW][kmascii_pkg::CTRL_BIT]
        && (raw_ch inside {[8'h41:8'h5f], [8'h61:8'h7a]})) begin
      ch = raw_ch & kmascii_pkg::CTRL_KEEP;
    end
  end

  assign res_o.ch       = ch;
  assign res_o.caps_key = rows_i[kmascii_pkg::CAPS_ROW][kmascii_pkg::CAPS_BIT];

endmodule

>>> test/keyboard_matrix_to_ascii_fifo_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_matrix_to_ascii_fifo_unit_checker
// Watches both stream channels and predicts every result of the key scanner.
// ----------------------------------------------------------------------------
// Each accepted input transaction is run through a local copy of the
// scanner (key search, table choice, ctrl fold, ring and caps lock). The
// predicted result joins a queue. Each accepted output transaction is
// checked field by field against the oldest queued result.
// ----------------------------------------------------------------------------
module keyboard_matrix_to_ascii_fifo_unit_checker
  import kmascii_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [79:0] s_axis_tdata_i,   // row_0 [7:0] ... row_9 [79:72]
  input  logic        s_axis_tuser_i,   // cmd [0]
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [15:0] m_axis_tdata_i,   // key_byte [7:0], key_ready [8], caps_on [9]
  output int          outstanding_o,
  output int          err_count_o,
  output int          scans_o,
  output int          pops_o,
  output int          pushes_o
);

  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic              caps_on;
    logic              key_ready;
    logic [CHAR_W-1:0] key_byte;
  } key_result_t;

  // Unshifted key map; the caps map is this one with letters upper-cased.
  localparam logic [7:0] PLAIN_KEYS [TABLE_LEN] = '{
    8'h31, 8'h33, 8'h35, 8'h37, 8'h39, 8'h2d, 8'h00, 8'h00,
    8'h32, 8'h34, 8'h36, 8'h38, 8'h30, 8'h00, 8'h00, 8'h00,
    8'h71, 8'h65, 8'h74, 8'h75, 8'h6f, 8'h3d, 8'h00, 8'h00,
    8'h77, 8'h72, 8'h79, 8'h69, 8'h70, 8'h00, 8'h00, 8'h00,
    8'h61, 8'h64, 8'h67, 8'h6a, 8'h6c, 8'h00, 8'h00, 8'h00,
    8'h73, 8'h66, 8'h68, 8'h6b, 8'h3b, 8'h00, 8'h00, 8'h00,
    8'h7a, 8'h63, 8'h62, 8'h6d, 8'h2e, 8'h00, 8'h00, 8'h00,
    8'h78, 8'h76, 8'h6e, 8'h2c, 8'h2f, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h08, 8'h00, 8'h0c, 8'h0d, 8'h00, 8'h00, 8'h00,
    8'h1e, 8'h20, 8'h0a, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam logic [7:0] SHIFTED_KEYS [TABLE_LEN] = '{
    8'h21, 8'h23, 8'h25, 8'h27, 8'h29, 8'h2b, 8'h00, 8'h00,
    8'h22, 8'h24, 8'h26, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h3c, 8'h00, 8'h5d, 8'h40, 8'h3a, 8'h2a, 8'h00, 8'h00,
    8'h3e, 8'h5b, 8'h5c, 8'h3f, 8'h5e, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h60, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h01, 8'h0a, 8'h00, 8'h00, 8'h00,
    8'h1a, 8'h20, 8'h0b, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  logic [CHAR_W-1:0] ring_q [QUEUE_DEPTH];
  int                wr_idx;
  int                rd_idx;
  logic [CHAR_W-1:0] prev_char;
  logic              prev_caps_key;
  logic              caps_lock_q;
  int                push_total;
  int                results_seen;
  key_result_t       expected_q [$];

  assign pushes_o = push_total;

  function automatic int ring_bump(int idx);
    return (idx == QUEUE_DEPTH - 1) ? 0 : idx + 1;
  endfunction

  function automatic logic [CHAR_W-1:0] table_char(tbl_sel_e sel, int idx);
    logic [CHAR_W-1:0] c;
    c = (sel == TBL_SEL_SHIFT) ? SHIFTED_KEYS[idx] : PLAIN_KEYS[idx];
    if (sel == TBL_SEL_CAPS && c >= "a" && c <= "z")
      c = c - 8'h20;
    return c;
  endfunction

  // Applies one transaction to the local scanner state, returns its result.
  function automatic key_result_t advance_keyboard(cmd_e cmd,
                                                   logic [NUM_ROWS*ROW_W-1:0] rows);
    key_result_t       res;
    tbl_sel_e          sel;
    logic [ROW_W-1:0]  row;
    logic [CHAR_W-1:0] ch;
    logic              caps_key;
    int                key_idx;
    res = '0;
    if (cmd == CMD_POP) begin
      res.key_byte = ring_q[rd_idx];
      rd_idx = ring_bump(rd_idx);
    end else begin
      if ((rows[SHIFT_ROW*ROW_W +: ROW_W] & SHIFT_MASK) != '0)
        sel = TBL_SEL_SHIFT;
      else if (caps_lock_q)
        sel = TBL_SEL_CAPS;
      else
        sel = TBL_SEL_NORMAL;
      // walk backwards so the lowest row / lowest bit is the last hit
      key_idx = -1;
      for (int r = NUM_ROWS - 1; r >= 0; r--) begin
        row = rows[r*ROW_W +: ROW_W];
        if (r == SHIFT_ROW)
          row = row & SHIFT_ROW_SRCH;
        for (int b = ROW_W - 1; b >= 0; b--)
          if (row[b])
            key_idx = r * ROW_W + b;
      end
      ch = (key_idx < 0) ? '0 : table_char(sel, key_idx);
      if (rows[CTRL_ROW*ROW_W + CTRL_BIT] &&
          ((ch >= "A" && ch <= "_") || (ch >= "a" && ch <= "z")))
        ch = ch & CTRL_KEEP;
      if (ch != '0 && ch != prev_char) begin
        ring_q[wr_idx] = ch;
        wr_idx = ring_bump(wr_idx);
        push_total++;
      end
      prev_char = ch;
      caps_key = rows[CAPS_ROW*ROW_W + CAPS_BIT];
      if (caps_key && !prev_caps_key)
        caps_lock_q = !caps_lock_q;
      prev_caps_key = caps_key;
    end
    res.key_ready = (rd_idx != wr_idx);
    res.caps_on   = caps_lock_q;
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (err_count_o < MAX_PRINTED)
      $display("%0t: result %0d %s: got 0x%0h, expected 0x%0h",
               $time, results_seen, what, got, want);
    err_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    key_result_t want;
    key_result_t got;
    logic        in_acc;
    logic        out_acc;
    if (!rst_ni) begin
      for (int i = 0; i < QUEUE_DEPTH; i++)
        ring_q[i] = '0;
      wr_idx        = 0;
      rd_idx        = 0;
      prev_char     = '0;
      prev_caps_key = 1'b0;
      caps_lock_q   = 1'b0;
      push_total    = 0;
      results_seen  = 0;
      err_count_o   = 0;
      expected_q.delete();
      outstanding_o <= 0;
      scans_o       <= 0;
      pops_o        <= 0;
    end else begin
      in_acc  = s_axis_tvalid_i && s_axis_tready_i;
      out_acc = m_axis_tvalid_i && m_axis_tready_i;
      if (in_acc) begin
        expected_q.push_back(advance_keyboard(cmd_e'(s_axis_tuser_i), s_axis_tdata_i));
        if (cmd_e'(s_axis_tuser_i) == CMD_POP)
          pops_o <= pops_o + 1;
        else
          scans_o <= scans_o + 1;
      end
      if (out_acc) begin
        got = key_result_t'(m_axis_tdata_i[9:0]);
        if (expected_q.size() == 0) begin
          report_mismatch("arrived with nothing expected", m_axis_tdata_i, 0);
        end else begin
          want = expected_q.pop_front();
          if (got.key_byte !== want.key_byte)
            report_mismatch("key_byte", got.key_byte, want.key_byte);
          if (got.key_ready !== want.key_ready)
            report_mismatch("key_ready", got.key_ready, want.key_ready);
          if (got.caps_on !== want.caps_on)
            report_mismatch("caps_on", got.caps_on, want.caps_on);
        end
        results_seen++;
      end
      outstanding_o <= outstanding_o + int'(in_acc) - int'(out_acc);
    end
  end

endmodule

>>> test/keyboard_matrix_to_ascii_fifo_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_matrix_to_ascii_fifo_unit_tb
// Stimulus and verdict for the key matrix scanner with its character ring.
// ----------------------------------------------------------------------------
// A directed run fills the ring, wraps it and walks through shift, caps,
// ctrl, empty table slots and pops on an empty ring. Random traffic then
// mixes key presses with modifiers, held keys, releases, noisy matrices and
// pops, under three idle mixes on the two channels. A separate checker
// predicts and compares every result; this module only drives and decides.
// ----------------------------------------------------------------------------
module keyboard_matrix_to_ascii_fifo_unit_tb;
  import kmascii_pkg::*;

  localparam int RESET_CYCLES = 9;
  localparam int STALL_LIMIT  = 2000;  // cycles with no transaction on either side
  localparam int DRAIN_CYCLES = 8;     // idle clocks after the last result

  // Item counts per idle mix; roughly 1000 random items in total.
  localparam int MIX_A_ITEMS = 400;
  localparam int MIX_B_ITEMS = 300;
  localparam int MIX_C_ITEMS = 300;

  // Bit positions of the modifier keys inside the flat 80-bit matrix.
  localparam int SHIFT_L_BIT = 0;
  localparam int SHIFT_R_BIT = 5;
  localparam int SHIFT_L_KEY = SHIFT_ROW * ROW_W + SHIFT_L_BIT;
  localparam int SHIFT_R_KEY = SHIFT_ROW * ROW_W + SHIFT_R_BIT;
  localparam int CTRL_KEY    = CTRL_ROW * ROW_W + CTRL_BIT;
  localparam int CAPS_KEY    = CAPS_ROW * ROW_W + CAPS_BIT;

  typedef logic [NUM_ROWS*ROW_W-1:0] matrix_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  matrix_t     s_tdata = '0;
  logic        s_tuser = CMD_SCAN;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          stall_cycles = 0;
  matrix_t     held_rows = '0;

  int          outstanding;
  int          errs;
  int          scans;
  int          pops;
  int          pushes;

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  keyboard_matrix_to_ascii_fifo_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  keyboard_matrix_to_ascii_fifo_unit_checker key_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .outstanding_o   (outstanding),
    .err_count_o     (errs),
    .scans_o         (scans),
    .pops_o          (pops),
    .pushes_o        (pushes)
  );

  // Receiver: ready drops at random, at the rate of the current idle mix.
  always @(posedge clk) begin
    if (!rst_n)
      m_tready <= 1'b0;
    else
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: a run that stops moving is a failure.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("FAIL keyboard_matrix_to_ascii_fifo_unit");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic matrix_t key_bit(int idx);
    return matrix_t'(1) << idx;
  endfunction

  // One input transaction: optional idle gap, then hold valid until accepted.
  // Valid is only lowered for a gap, so a back-to-back item never toggles it
  // within one time step.
  task automatic send_item(cmd_e cmd, matrix_t rows);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= rows;
    s_tuser  <= cmd;
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
  endtask

  task automatic send_scan(matrix_t rows);
    send_item(CMD_SCAN, rows);
  endtask

  // Random traffic: mostly well-formed key events, some pops, some noise.
  task automatic send_random_item();
    matrix_t rows;
    int      pick;
    rows = {16'($urandom), $urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 25) begin
      // pop; the row bits ride along and must be ignored
      send_item(CMD_POP, rows);
    end else if (pick < 35) begin
      held_rows = '0;
      send_scan(held_rows);
    end else if (pick < 50) begin
      // key still held: same character again, no new push
      send_scan(held_rows);
    end else if (pick < 90) begin
      rows = key_bit($urandom_range(NUM_ROWS * ROW_W - 1));
      if ($urandom_range(99) < 30)
        rows |= key_bit($urandom_range(1) ? SHIFT_L_KEY : SHIFT_R_KEY);
      if ($urandom_range(99) < 20)
        rows |= key_bit(CTRL_KEY);
      if ($urandom_range(99) < 15)
        rows |= key_bit(CAPS_KEY);
      held_rows = rows;
      send_scan(rows);
    end else begin
      // noisy matrix; blank some rows so the deeper rows get picked too
      for (int r = 0; r < NUM_ROWS; r++)
        if ($urandom_range(1))
          rows[r*ROW_W +: ROW_W] = '0;
      held_rows = rows;
      send_scan(rows);
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 31;
    recv_idle_pct <= 66;

    // Fill the whole ring before the first pop: after eight distinct keys
    // every entry holds a real character, so no pop can read a stale slot.
    // The eighth push wraps the write pointer onto the read pointer, so the
    // ring also overflows and reads as empty here.
    for (int b = 0; b < 6; b++)
      send_scan(key_bit(b));
    send_scan(key_bit(ROW_W));
    send_scan(key_bit(ROW_W + 1));

    // pop on an empty ring still returns a byte and advances
    send_item(CMD_POP, '1);
    // no key at all, then the shift keys alone (never picked as a key)
    send_scan('0);
    send_scan(key_bit(SHIFT_L_KEY) | key_bit(SHIFT_R_KEY));
    send_scan(key_bit(0) | key_bit(SHIFT_L_KEY));
    // every key down: same shifted char as before (no push), caps toggles on
    send_scan('1);
    send_scan('0);
    // caps table, then ctrl folding of a letter and of a shifted symbol
    send_scan(key_bit(2 * ROW_W));
    send_scan(key_bit(2 * ROW_W) | key_bit(CTRL_KEY));
    send_scan(key_bit(3 * ROW_W + 4) | key_bit(SHIFT_R_KEY) | key_bit(CTRL_KEY));
    // caps key on its own sits in an empty table slot; second scan is held
    send_scan(key_bit(CAPS_KEY));
    send_scan(key_bit(CAPS_KEY));
    // row 8 non-shift key, ctrl on a code outside the letter ranges,
    // ctrl on a lower-case letter
    send_scan(key_bit(SHIFT_ROW * ROW_W + 1));
    send_scan(key_bit(CTRL_ROW * ROW_W) | key_bit(CTRL_KEY));
    send_scan(key_bit(4 * ROW_W) | key_bit(CTRL_KEY));
    repeat (4) send_item(CMD_POP, '0);

    repeat (MIX_A_ITEMS) send_random_item();

    send_idle_pct = 66;
    recv_idle_pct <= 31;
    repeat (MIX_B_ITEMS) send_random_item();

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    repeat (MIX_C_ITEMS) send_random_item();

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d scan ticks and %0d pops; %0d characters entered the ring.",
             scans, pops, pushes);
    $display("Idle mixes sender/receiver: 31/66, 66/31, then none; %0d mismatches.",
             errs);
    if (errs == 0)
      $display("PASS keyboard_matrix_to_ascii_fifo_unit");
    else
      $display("FAIL keyboard_matrix_to_ascii_fifo_unit");
    $finish;
  end

endmodule
